>>> rtl/box_blur_row_unit_assert.svh
// assertion macros used by the checker of the blur row unit
`ifndef BOX_BLUR_ROW_UNIT_ASSERT_SVH
`define BOX_BLUR_ROW_UNIT_ASSERT_SVH

// same-cycle implication
`define BBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box blur row unit check failed");

// next-cycle implication
`define BBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box blur row unit check failed");

`endif

>>> rtl/bbr_pkg.sv
`timescale 1ns / 1ps
package bbr_pkg;

  localparam int PIX_W      = 8;
  localparam int RADIUS_W   = 4;
  localparam int MAX_RADIUS = 15;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int DIAM_W     = 5;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 13;
  localparam int SCALE_W    = 25;
  localparam int FRAC_BITS  = 24;
  localparam int PROD_W     = SUM_W + SCALE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RADIUS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_RADIUS  = 1'b0,
    REG_RIGHT_RADIUS = 1'b1
  } reg_idx_t;

  // floor(2^24 / kernel_size), indexed by left + right
  localparam logic [SCALE_W-1:0] SCALE_TABLE [WIN_DEPTH] = '{
    25'd16777216, 25'd8388608, 25'd5592405, 25'd4194304, 25'd3355443,
    25'd2796202,  25'd2396745, 25'd2097152, 25'd1864135, 25'd1677721,
    25'd1525201,  25'd1398101, 25'd1290555, 25'd1198372, 25'd1118481,
    25'd1048576,  25'd986895,  25'd932067,  25'd883011,  25'd838860,
    25'd798915,   25'd762600,  25'd729444,  25'd699050,  25'd671088,
    25'd645277,   25'd621378,  25'd599186,  25'd578524,  25'd559240,
    25'd541200
  };

  localparam logic [RADIUS_W-1:0] RESET_RADIUS = 4'd1;
  localparam logic [SCALE_W-1:0]  RESET_SCALE  = SCALE_TABLE[2];

  typedef struct packed {
    logic [RADIUS_W-1:0] left;
    logic [RADIUS_W-1:0] right;
  } radii_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             end_of_row;
  } item_t;

  // one result slot per cycle from the sequencer, while emit is set and the output advances
  typedef struct packed {
    logic             emit;
    logic             pad;
    logic             last;
    logic             row_done;
    logic             clear;
    logic [PIX_W-1:0] pix;
  } seq_ctrl_t;

endpackage

>>> rtl/bbr_stream_ifs.sv
`timescale 1ns / 1ps
interface bbr_in_if;
  logic                      valid;
  logic                      ready;
  logic [bbr_pkg::PIX_W-1:0] pixel;
  logic                      end_of_row;

  modport source (output valid, output pixel, output end_of_row, input ready);
  modport sink (input valid, input pixel, input end_of_row, output ready);
endinterface

interface bbr_out_if;
  logic                      valid;
  logic                      ready;
  logic [bbr_pkg::PIX_W-1:0] blurred;
  logic                      last_of_run;
  logic                      row_done;

  modport source (output valid, output blurred, output last_of_run, output row_done,
                  input ready);
  modport sink (input valid, input blurred, input last_of_run, input row_done,
                output ready);
endinterface

>>> rtl/bbr_seq.sv
`timescale 1ns / 1ps
module bbr_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               cfg_clear,
  input  bbr_pkg::radii_t    radii,
  input  logic               in_valid,
  input  bbr_pkg::item_t     in_item,
  output logic               in_ready,
  output bbr_pkg::seq_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_TAP   = 4'b0010,
    PH_FLUSH = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_t;

  logic                      busy_r, busy_nxt;
  bbr_pkg::item_t            item_r, item_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [bbr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      row_start_r, row_start_nxt;

  logic                       emit, fin, accept, row_start_eff;
  logic                       pad, row_close;
  logic [bbr_pkg::PIX_W-1:0]  pix_sel;
  logic                       left_gt, right_gt;
  logic [bbr_pkg::DIAM_W-1:0] diam;
  logic [bbr_pkg::CNT_W-1:0]  lead_cnt, trail_cnt;
  phase_t                     step_phase;
  logic [bbr_pkg::CNT_W-1:0]  step_cnt;

  assign left_gt   = radii.left > radii.right;
  assign right_gt  = radii.right > radii.left;
  assign diam      = bbr_pkg::DIAM_W'(radii.left) + bbr_pkg::DIAM_W'(radii.right);
  assign lead_cnt  = bbr_pkg::CNT_W'(radii.right - radii.left) - bbr_pkg::CNT_W'(1);
  assign trail_cnt = bbr_pkg::CNT_W'(radii.left - radii.right) - bbr_pkg::CNT_W'(1);

  assign emit = busy_r && adv;

  always_comb begin
    pad        = 1'b0;
    pix_sel    = item_r.pixel;
    fin        = 1'b0;
    step_phase = phase_r;
    step_cnt   = cnt_r - bbr_pkg::CNT_W'(1);
    unique case (phase_r)
      PH_LEAD: begin
        pad = 1'b1;
        if (cnt_r == '0) begin
          step_phase = PH_TAP;
        end
      end
      PH_TAP: begin
        if (!item_r.end_of_row) begin
          fin = 1'b1;
        end else if (diam != '0) begin
          step_phase = PH_FLUSH;
          step_cnt   = diam - bbr_pkg::DIAM_W'(1);
        end else if (left_gt) begin
          step_phase = PH_TRAIL;
          step_cnt   = trail_cnt;
        end else begin
          fin = 1'b1;
        end
      end
      PH_FLUSH: begin
        pix_sel = '0;
        if (cnt_r == '0) begin
          if (left_gt) begin
            step_phase = PH_TRAIL;
            step_cnt   = trail_cnt;
          end else begin
            fin = 1'b1;
          end
        end
      end
      PH_TRAIL: begin
        pad = 1'b1;
        if (cnt_r == '0) begin
          fin = 1'b1;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  assign row_close = emit && fin && item_r.end_of_row;

  // emit, pad, last, row_done, clear, pix
  assign ctrl = {emit, pad, fin, fin && item_r.end_of_row, row_close, pix_sel};

  assign in_ready      = !busy_r || (emit && fin);
  assign accept        = in_valid && in_ready;
  // a row that closes in this cycle makes the next item a row start
  assign row_start_eff = row_start_r || row_close;

  always_comb begin
    busy_nxt      = busy_r;
    item_nxt      = item_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    row_start_nxt = row_start_eff;
    if (emit) begin
      phase_nxt = step_phase;
      cnt_nxt   = step_cnt;
      if (fin) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt      = 1'b1;
      item_nxt      = in_item;
      row_start_nxt = 1'b0;
      if (row_start_eff && right_gt) begin
        phase_nxt = PH_LEAD;
        cnt_nxt   = lead_cnt;
      end else begin
        phase_nxt = PH_TAP;
      end
    end
    if (cfg_clear) begin
      row_start_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_TAP;
      cnt_r       <= '0;
      row_start_r <= 1'b1;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      row_start_r <= row_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

>>> rtl/bbr_tap.sv
`timescale 1ns / 1ps
module bbr_tap (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bbr_pkg::seq_ctrl_t          ctrl,
  input  logic                        cfg_clear,
  input  bbr_pkg::radii_t             radii,
  input  logic [bbr_pkg::SCALE_W-1:0] scale,
  output logic [bbr_pkg::PIX_W-1:0]   blurred
);

  logic [bbr_pkg::PIX_W-1:0] win_r     [bbr_pkg::WIN_DEPTH];
  logic [bbr_pkg::PIX_W-1:0] win_shift [bbr_pkg::WIN_DEPTH];
  logic [bbr_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_tap;
  logic [bbr_pkg::PROD_W-1:0] prod;
  logic [bbr_pkg::DIAM_W-1:0] diam;
  logic [bbr_pkg::PIX_W-1:0]  leave;
  logic                       tap_en, clear;

  assign tap_en = ctrl.emit && !ctrl.pad;
  assign clear  = cfg_clear || ctrl.clear;
  assign diam   = bbr_pkg::DIAM_W'(radii.left) + bbr_pkg::DIAM_W'(radii.right);

  // newest pixel at index 0
  always_comb begin
    win_shift[0] = ctrl.pix;
    for (int i = 1; i < bbr_pkg::WIN_DEPTH; i++) begin
      win_shift[i] = win_r[i-1];
    end
  end

  assign sum_tap = sum_r + bbr_pkg::SUM_W'(ctrl.pix);
  assign prod    = bbr_pkg::PROD_W'(sum_tap) * bbr_pkg::PROD_W'(scale);
  assign blurred = prod[bbr_pkg::FRAC_BITS +: bbr_pkg::PIX_W];

  // tap that drops out of the kernel after this output
  assign leave = win_shift[diam];

  always_comb begin
    sum_nxt = sum_r;
    if (clear) begin
      sum_nxt = '0;
    end else if (tap_en) begin
      sum_nxt = sum_tap - bbr_pkg::SUM_W'(leave);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < bbr_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      sum_r <= sum_nxt;
      for (int i = 0; i < bbr_pkg::WIN_DEPTH; i++) begin
        if (clear) begin
          win_r[i] <= '0;
        end else if (tap_en) begin
          win_r[i] <= win_shift[i];
        end
      end
    end
  end

endmodule

>>> rtl/box_blur_row_unit.sv
`timescale 1ns / 1ps
// One-dimensional box blur of a stream of 8-bit alpha pixels with a kernel of
// left_radius+right_radius+1 equal taps; each output is
// (window_sum * floor(2^24/kernel_size)) >> 24 over the zero-padded row, so a
// row of w pixels gives w + 2*max(left_radius, right_radius) results. Results
// leave one per cycle, while the output is taken, through a single output
// register, which sets the rate: an interior pixel gives 1 result, the first
// pixel of a row 1 + max(0, right-left) results and the last pixel of a row
// 1 + left + right + max(0, left-right) results. An input pixel is registered
// in the sequencer and its result then in the output register. A radius write
// clears the row in progress and reloads the reciprocal from a constant table
// in the same cycle; write radii only while the block is idle.
module box_blur_row_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  bbr_in_if.sink                         in_ch,
  bbr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data
);

  bbr_pkg::radii_t              radii_r, radii_nxt;
  logic [bbr_pkg::SCALE_W-1:0]  scale_r, scale_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [bbr_pkg::PIX_W-1:0]    blurred_r;
  logic                         last_r, row_done_r;

  bbr_pkg::item_t               in_item;
  bbr_pkg::seq_ctrl_t           ctrl;
  logic [bbr_pkg::PIX_W-1:0]    tap_value;
  logic                         adv;
  logic [bbr_pkg::DIAM_W-1:0]   diam_nxt;

  always_comb begin
    radii_nxt = radii_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bbr_pkg::REG_LEFT_RADIUS:  radii_nxt.left  = cfg_data;
        bbr_pkg::REG_RIGHT_RADIUS: radii_nxt.right = cfg_data;
        default: radii_nxt = radii_r;
      endcase
    end
  end

  assign diam_nxt  = bbr_pkg::DIAM_W'(radii_nxt.left) + bbr_pkg::DIAM_W'(radii_nxt.right);
  assign scale_nxt = cfg_we ? bbr_pkg::SCALE_TABLE[diam_nxt] : scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radii_r.left  <= bbr_pkg::RESET_RADIUS;
      radii_r.right <= bbr_pkg::RESET_RADIUS;
      scale_r       <= bbr_pkg::RESET_SCALE;
    end else begin
      radii_r <= radii_nxt;
      scale_r <= scale_nxt;
    end
  end

  assign in_item = {in_ch.pixel, in_ch.end_of_row};

  // output register is empty or is taken this cycle
  assign adv = !out_valid_r || out_ch.ready;

  bbr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg_clear (cfg_we),
    .radii     (radii_r),
    .in_valid  (in_ch.valid),
    .in_item   (in_item),
    .in_ready  (in_ch.ready),
    .ctrl      (ctrl)
  );

  bbr_tap u_tap (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg_clear (cfg_we),
    .radii     (radii_r),
    .scale     (scale_r),
    .blurred   (tap_value)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      blurred_r  <= ctrl.pad ? '0 : tap_value;
      last_r     <= ctrl.last;
      row_done_r <= ctrl.row_done;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.blurred     = blurred_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.row_done    = row_done_r;

endmodule

>>> rtl/bbr_checker.sv
`timescale 1ns / 1ps
`include "box_blur_row_unit_assert.svh"
module bbr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bbr_pkg::PIX_W-1:0] out_blurred,
  input logic                      out_last_of_run,
  input logic                      out_row_done
);

  logic out_stall, out_take;

  assign out_stall = out_valid && !out_ready;
  assign out_take  = out_valid && out_ready;

  // a stalled result holds
  `BBR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_blurred) && $stable(out_last_of_run) && $stable(out_row_done))

  // the end of a widened row always closes a run
  `BBR_ASSERT_NOW(a_row_done_last, clk, rst_n, out_valid && out_row_done, out_last_of_run)

  // a run of results leaves without gaps
  `BBR_ASSERT_NEXT(a_run_no_gap, clk, rst_n, out_take && !out_last_of_run, out_valid)

endmodule

bind box_blur_row_unit bbr_checker u_bbr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_blurred     (out_ch.blurred),
  .out_last_of_run (out_ch.last_of_run),
  .out_row_done    (out_ch.row_done)
);

>>> sim/box_blur_row_unit_tb.sv
`timescale 1ns / 1ps
module box_blur_row_unit_tb;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [bbr_pkg::PIX_W-1:0] blurred;
    logic                      last_of_run;
    logic                      row_done;
  } blur_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data;

  bbr_in_if  in_ch ();
  bbr_out_if out_ch ();

  box_blur_row_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // blur predictor state
  logic [bbr_pkg::PIX_W-1:0]   win_px [bbr_pkg::WIN_DEPTH];
  logic [bbr_pkg::SUM_W-1:0]   win_sum;
  logic [bbr_pkg::SCALE_W-1:0] recip;
  bit                          row_fresh;
  int                          left_r;
  int                          right_r;

  blur_result_t pending_blur_q[$];
  blur_result_t want;

  int error_count;
  int cycle_count;
  int sink_hold;
  bit src_idle;
  bit sink_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void clear_blur_row();
    for (int k = 0; k < bbr_pkg::WIN_DEPTH; k++) win_px[k] = '0;
    win_sum   = '0;
    row_fresh = 1'b1;
  endfunction

  function automatic void load_radii(input int l, input int r);
    left_r  = l;
    right_r = r;
    recip   = bbr_pkg::SCALE_W'((1 << bbr_pkg::FRAC_BITS) / (l + r + 1));
    clear_blur_row();
  endfunction

  // shift one pixel into the window and return the scaled box sum
  function automatic logic [bbr_pkg::PIX_W-1:0] shift_tap(
      input logic [bbr_pkg::PIX_W-1:0] pix);
    logic [bbr_pkg::PROD_W-1:0] prod;
    int                         d;
    d = left_r + right_r;
    for (int k = bbr_pkg::WIN_DEPTH - 1; k > 0; k--) win_px[k] = win_px[k-1];
    win_px[0] = pix;
    win_sum   = win_sum + pix;
    prod      = win_sum * recip;
    win_sum   = win_sum - win_px[d];
    return prod[bbr_pkg::FRAC_BITS+bbr_pkg::PIX_W-1:bbr_pkg::FRAC_BITS];
  endfunction

  function automatic void put_blur(input logic [bbr_pkg::PIX_W-1:0] v, input bit last,
                                   input bit eor);
    blur_result_t res;
    res.blurred     = v;
    res.last_of_run = last;
    res.row_done    = last && eor;
    pending_blur_q.push_back(res);
  endfunction

  function automatic void predict_blur_run(input logic [bbr_pkg::PIX_W-1:0] pix,
                                           input bit eor);
    int lead;
    int flush;
    int trail;
    logic [bbr_pkg::PIX_W-1:0] v;
    lead  = (row_fresh && right_r > left_r) ? right_r - left_r : 0;
    flush = eor ? left_r + right_r : 0;
    trail = (eor && left_r > right_r) ? left_r - right_r : 0;
    row_fresh = 1'b0;
    for (int k = 0; k < lead; k++) put_blur('0, 1'b0, eor);
    v = shift_tap(pix);
    put_blur(v, flush == 0 && trail == 0, eor);
    for (int k = 0; k < flush; k++) begin
      v = shift_tap('0);
      put_blur(v, k == flush - 1 && trail == 0, eor);
    end
    for (int k = 0; k < trail; k++) put_blur('0, k == trail - 1, eor);
    if (eor) clear_blur_row();
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_blur_q.size() == 0) begin
        $error("unexpected result: blurred %0d last_of_run %0b row_done %0b",
               out_ch.blurred, out_ch.last_of_run, out_ch.row_done);
        error_count++;
      end else begin
        want = pending_blur_q.pop_front();
        if (out_ch.blurred !== want.blurred) begin
          $error("blurred mismatch: expected %0d, got %0d", want.blurred, out_ch.blurred);
          error_count++;
        end
        if (out_ch.last_of_run !== want.last_of_run) begin
          $error("last_of_run mismatch: expected %0b, got %0b",
                 want.last_of_run, out_ch.last_of_run);
          error_count++;
        end
        if (out_ch.row_done !== want.row_done) begin
          $error("row_done mismatch: expected %0b, got %0b", want.row_done, out_ch.row_done);
          error_count++;
        end
      end
    end
  end

  // result side: random stall bursts, or a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_pixel(input logic [bbr_pkg::PIX_W-1:0] pix, input bit eor);
    in_ch.valid      <= 1'b1;
    in_ch.pixel      <= pix;
    in_ch.end_of_row <= eor;
    do @(posedge clk); while (!in_ch.ready);
    predict_blur_run(pix, eor);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_blur_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // both radii, left then right on consecutive edges; the block must be idle
  task automatic set_radii(input int l, input int r);
    cfg_we    <= 1'b1;
    cfg_index <= bbr_pkg::REG_LEFT_RADIUS;
    cfg_data  <= bbr_pkg::CFG_DATA_W'(l);
    @(posedge clk);
    load_radii(l, right_r);
    cfg_index <= bbr_pkg::REG_RIGHT_RADIUS;
    cfg_data  <= bbr_pkg::CFG_DATA_W'(r);
    @(posedge clk);
    load_radii(l, r);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [bbr_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return bbr_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_rows(input int count, input bit close_row);
    int row_left;
    row_left = $urandom_range(1, 12);
    for (int k = 0; k < count; k++) begin
      row_left--;
      push_pixel(rand_pixel(), (row_left == 0) || (close_row && k == count - 1));
      if (row_left == 0) row_left = $urandom_range(1, 12);
    end
  endtask

  task automatic test_reset_radii();
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd128, 1'b1);
    drain_results();
  endtask

  task automatic test_extreme_radii();
    // all leading zeros, then all trailing zeros, then the widest kernel, then a single tap
    set_radii(0, 15);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd254, 1'b1);
    drain_results();
    set_radii(15, 0);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd7, 1'b0);
    push_pixel(8'd200, 1'b1);
    drain_results();
    set_radii(15, 15);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b1);
    drain_results();
    set_radii(0, 0);
    push_pixel(8'haa, 1'b0);
    push_pixel(8'h55, 1'b1);
    drain_results();
  endtask

  task automatic test_row_abort();
    set_radii(2, 3);
    push_pixel(8'd250, 1'b0);
    push_pixel(8'd17, 1'b0);
    push_pixel(8'd99, 1'b0);
    drain_results();
    // row still open: the write throws the window away
    set_radii(2, 1);
    push_pixel(8'd90, 1'b0);
    push_pixel(8'd10, 1'b1);
    drain_results();
  endtask

  task automatic test_output_hold();
    set_radii(4, 4);
    sink_hold = 80;
    send_rows(30, 1'b1);
    drain_results();
  endtask

  task automatic test_random_rows();
    int l;
    int r;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          l = 0;
          r = 0;
        end
        1: begin
          l = 15;
          r = 15;
        end
        2: begin
          l = 0;
          r = 15;
        end
        3: begin
          l = 15;
          r = 0;
        end
        default: begin
          l = $urandom_range(0, 15);
          r = $urandom_range(0, 15);
        end
      endcase
      if (phase == 7) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end
      set_radii(l, r);
      if (phase == 4) begin
        send_rows(22, 1'b0);
        drain_results();
        send_rows(23, 1'($urandom_range(0, 1)));
      end else begin
        send_rows(45, 1'($urandom_range(0, 1)));
      end
      drain_results();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = bbr_pkg::REG_LEFT_RADIUS;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.pixel      = '0;
    in_ch.end_of_row = 1'b0;
    error_count      = 0;
    sink_hold        = 0;
    src_idle         = 1'b1;
    sink_idle        = 1'b1;
    load_radii(1, 1);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_radii();
    test_extreme_radii();
    test_row_abort();
    test_output_hold();
    test_random_rows();
    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bbr_pkg.sv
rtl/bbr_stream_ifs.sv
rtl/bbr_seq.sv
rtl/bbr_tap.sv
rtl/box_blur_row_unit.sv
rtl/bbr_checker.sv
sim/box_blur_row_unit_tb.sv
